FILE: hw/rtl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_UNTERM_STRING = 3'd0;
   localparam logic [2:0] ERR_UNTERM_ESCAPE = 3'd1;
   localparam logic [2:0] ERR_TRUNC_HEX     = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX       = 3'd3;
   localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd4;

   // What the main part of a command carries.
   localparam logic [1:0] MAIN_NONE = 2'd0;
   localparam logic [1:0] MAIN_RAW  = 2'd1;
   localparam logic [1:0] MAIN_CP   = 2'd2;

   // What closes a command.
   localparam logic [1:0] TAIL_NONE = 2'd0;
   localparam logic [1:0] TAIL_END  = 2'd1;
   localparam logic [1:0] TAIL_ERR  = 2'd2;

   localparam logic [20:0] REPL_CP   = 21'h00FFFD;
   localparam logic [20:0] SUPP_BASE = 21'h010000;
   localparam logic [15:0] HI_MIN    = 16'hD800;
   localparam logic [15:0] HI_MAX    = 16'hDBFF;
   localparam logic [15:0] LO_MIN    = 16'hDC00;
   localparam logic [15:0] LO_MAX    = 16'hDFFF;

   // One classified request: an optional replacement character, then a raw
   // byte or a code point, then an optional string end or error.
   typedef struct packed {
      logic        pre_repl;
      logic [1:0]  main_sel;
      logic [20:0] main_val;
      logic [1:0]  tail_sel;
      logic [2:0]  err_code;
   } cmd_type;

endpackage

FILE: hw/rtl/jsu_front.sv
// Front end: accepts requests, tracks the string and escape phase, issues commands.
module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_end,
   output logic       push,
   output cmd_type    push_cmd,
   input  logic       q_full
);

   localparam logic [3:0] PH_IDLE        = 4'd0;
   localparam logic [3:0] PH_STR         = 4'd1;
   localparam logic [3:0] PH_ESC         = 4'd2;
   localparam logic [3:0] PH_HEX1        = 4'd3;
   localparam logic [3:0] PH_AFTER_HI    = 4'd4;
   localparam logic [3:0] PH_AFTER_HI_BS = 4'd5;
   localparam logic [3:0] PH_HEX2        = 4'd6;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] hex_ff, hex_in;
   logic [1:0]  count_ff, count_in;
   logic [9:0]  high_ff, high_in;

   logic        accept;
   logic [7:0]  c;
   cmd_type     cmd;

   logic [1:0]  sb_main, sb_tail;
   logic [3:0]  sb_phase;
   logic [1:0]  eb_main, eb_tail;
   logic [7:0]  eb_val;
   logic [3:0]  eb_phase;
   logic        eb_hex;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] acc;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_data_byte;
   assign acc       = {hex_ff[11:0], hex_val};

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         hex_val = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   // Effect of an ordinary string byte.
   always_comb begin
      sb_main  = MAIN_RAW;
      sb_tail  = TAIL_NONE;
      sb_phase = PH_STR;
      if (c == CH_QUOTE) begin
         sb_main  = MAIN_NONE;
         sb_tail  = TAIL_END;
         sb_phase = PH_IDLE;
      end else if (c == CH_BSL) begin
         sb_main  = MAIN_NONE;
         sb_phase = PH_ESC;
      end
   end

   // Effect of the byte that follows a backslash.
   always_comb begin
      eb_main  = MAIN_RAW;
      eb_tail  = TAIL_NONE;
      eb_val   = c;
      eb_phase = PH_STR;
      eb_hex   = 1'b0;
      case (c)
         CH_QUOTE, CH_BSL, CH_SLASH: eb_val = c;
         CH_B: eb_val = 8'h08;
         CH_F: eb_val = 8'h0C;
         CH_N: eb_val = 8'h0A;
         CH_R: eb_val = 8'h0D;
         CH_T: eb_val = 8'h09;
         CH_U: begin
            eb_main  = MAIN_NONE;
            eb_phase = PH_HEX1;
            eb_hex   = 1'b1;
         end
         default: begin
            eb_main  = MAIN_NONE;
            eb_tail  = TAIL_ERR;
            eb_phase = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      hex_in   = hex_ff;
      count_in = count_ff;
      high_in  = high_ff;
      cmd      = '0;
      if (req_is_end) begin
         phase_in = PH_IDLE;
         case (phase_ff)
            PH_STR: begin
               cmd.tail_sel = TAIL_ERR;
               cmd.err_code = ERR_UNTERM_STRING;
            end
            PH_ESC: begin
               cmd.tail_sel = TAIL_ERR;
               cmd.err_code = ERR_UNTERM_ESCAPE;
            end
            PH_HEX1, PH_HEX2: begin
               cmd.tail_sel = TAIL_ERR;
               cmd.err_code = ERR_TRUNC_HEX;
            end
            PH_AFTER_HI: begin
               cmd.pre_repl = 1'b1;
               cmd.tail_sel = TAIL_ERR;
               cmd.err_code = ERR_UNTERM_STRING;
            end
            PH_AFTER_HI_BS: begin
               cmd.pre_repl = 1'b1;
               cmd.tail_sel = TAIL_ERR;
               cmd.err_code = ERR_UNTERM_ESCAPE;
            end
            default: ;
         endcase
      end else begin
         case (phase_ff)
            PH_STR: begin
               cmd.main_sel = sb_main;
               cmd.main_val = {13'd0, c};
               cmd.tail_sel = sb_tail;
               phase_in     = sb_phase;
            end
            PH_ESC: begin
               cmd.main_sel = eb_main;
               cmd.main_val = {13'd0, eb_val};
               cmd.tail_sel = eb_tail;
               cmd.err_code = ERR_BAD_ESCAPE;
               phase_in     = eb_phase;
               if (eb_hex) begin
                  hex_in   = '0;
                  count_in = '0;
               end
            end
            PH_HEX1, PH_HEX2: begin
               if (!hex_ok) begin
                  cmd.tail_sel = TAIL_ERR;
                  cmd.err_code = ERR_BAD_HEX;
                  phase_in     = PH_IDLE;
               end else if (count_ff != 2'd3) begin
                  hex_in   = acc;
                  count_in = count_ff + 2'd1;
               end else begin
                  hex_in   = acc;
                  count_in = '0;
                  phase_in = PH_STR;
                  cmd.main_sel = MAIN_CP;
                  cmd.main_val = {5'd0, acc};
                  if (phase_ff == PH_HEX1) begin
                     if (acc inside {[HI_MIN:HI_MAX]}) begin
                        high_in      = acc[9:0];
                        phase_in     = PH_AFTER_HI;
                        cmd.main_sel = MAIN_NONE;
                     end else if (acc inside {[LO_MIN:LO_MAX]}) begin
                        cmd.main_val = REPL_CP;
                     end
                  end else begin
                     high_in = '0;
                     if (acc inside {[LO_MIN:LO_MAX]}) begin
                        cmd.main_val = SUPP_BASE + {1'b0, high_ff, acc[9:0]};
                     end else begin
                        cmd.pre_repl = 1'b1;
                        if (acc inside {[HI_MIN:HI_MAX]}) begin
                           cmd.main_val = REPL_CP;
                        end
                     end
                  end
               end
            end
            PH_AFTER_HI: begin
               if (c == CH_BSL) begin
                  phase_in = PH_AFTER_HI_BS;
               end else begin
                  cmd.pre_repl = 1'b1;
                  cmd.main_sel = sb_main;
                  cmd.main_val = {13'd0, c};
                  cmd.tail_sel = sb_tail;
                  high_in      = '0;
                  phase_in     = sb_phase;
               end
            end
            PH_AFTER_HI_BS: begin
               if (c == CH_U) begin
                  phase_in = PH_HEX2;
                  hex_in   = '0;
                  count_in = '0;
               end else begin
                  cmd.pre_repl = 1'b1;
                  cmd.main_sel = eb_main;
                  cmd.main_val = {13'd0, eb_val};
                  cmd.tail_sel = eb_tail;
                  cmd.err_code = ERR_BAD_ESCAPE;
                  high_in      = '0;
                  phase_in     = eb_phase;
               end
            end
            default: begin
               phase_in = (c == CH_QUOTE) ? PH_STR : PH_IDLE;
            end
         endcase
      end
      if (phase_in == PH_IDLE) begin
         hex_in   = '0;
         count_in = '0;
         high_in  = '0;
      end
   end

   assign push_cmd = cmd;
   assign push     = accept && (cmd.pre_repl || (cmd.main_sel != MAIN_NONE) ||
                                (cmd.tail_sel != TAIL_NONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hex_ff   <= '0;
         count_ff <= '0;
         high_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
         count_ff <= count_in;
         high_ff  <= high_in;
      end
   end

endmodule

FILE: hw/rtl/jsu_queue.sv
// Short first-word-fall-through command queue between front and back end.
module jsu_queue import jsu_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty,
   output logic    full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == FULL_CNT);
   assign head_cmd = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT) else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/jsu_back.sv
// Back end: expands each command into UTF-8 bytes and a closing result.
module jsu_back import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head_cmd,
   input  logic       q_empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   function automatic logic [3:0] utf8_len(input logic [20:0] cp);
      if (cp <= 21'h00007F) return 4'd1;
      if (cp <= 21'h0007FF) return 4'd2;
      if (cp <= 21'h00FFFF) return 4'd3;
      return 4'd4;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] j);
      logic [7:0] b;
      b = 8'h00;
      if (cp <= 21'h00007F) begin
         b = cp[7:0];
      end else if (cp <= 21'h0007FF) begin
         b = (j == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      end else if (cp <= 21'h00FFFF) begin
         case (j)
            2'd0:    b = {4'b1110, cp[15:12]};
            2'd1:    b = {2'b10, cp[11:6]};
            default: b = {2'b10, cp[5:0]};
         endcase
      end else begin
         case (j)
            2'd0:    b = {5'b11110, cp[20:18]};
            2'd1:    b = {2'b10, cp[17:12]};
            2'd2:    b = {2'b10, cp[11:6]};
            default: b = {2'b10, cp[5:0]};
         endcase
      end
      return b;
   endfunction

   cmd_type    cmd_ff;
   logic       busy_ff;
   logic [2:0] pos_ff;

   logic [3:0] repl_len, main_len, tail_len, total, p, j;
   logic       done;

   always_comb begin
      repl_len = cmd_ff.pre_repl ? utf8_len(REPL_CP) : 4'd0;
      case (cmd_ff.main_sel)
         MAIN_RAW: main_len = 4'd1;
         MAIN_CP:  main_len = utf8_len(cmd_ff.main_val);
         default:  main_len = 4'd0;
      endcase
      tail_len = (cmd_ff.tail_sel != TAIL_NONE) ? 4'd1 : 4'd0;
      total    = repl_len + main_len + tail_len;
      p        = {1'b0, pos_ff};
      j        = p - repl_len;

      rsp_out_byte   = 8'h00;
      rsp_kind       = KIND_DATA;
      rsp_error_code = ERR_UNTERM_STRING;
      if (p < repl_len) begin
         rsp_out_byte = utf8_byte(REPL_CP, pos_ff[1:0]);
      end else if (p < repl_len + main_len) begin
         rsp_out_byte = (cmd_ff.main_sel == MAIN_RAW) ? cmd_ff.main_val[7:0] :
                        utf8_byte(cmd_ff.main_val, j[1:0]);
      end else if (cmd_ff.tail_sel == TAIL_END) begin
         rsp_kind = KIND_END;
      end else begin
         rsp_kind       = KIND_ERROR;
         rsp_error_code = cmd_ff.err_code;
      end
   end

   assign rsp_valid = busy_ff;
   assign rsp_last  = (p == total - 4'd1);
   assign done      = rsp_valid && rsp_ready && rsp_last;
   assign pop       = !q_empty && (!busy_ff || done);

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         pos_ff  <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (rsp_valid && rsp_ready) begin
         pos_ff <= pos_ff + 3'd1;
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (p < total)) else $error("result position past command end");
   a_pos_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(pos_ff))
      else $error("result position moved while stalled");
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (done && !q_empty) |=> (busy_ff && pos_ff == 3'd0))
      else $error("queued command not taken after last result");

endmodule

FILE: hw/rtl/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// Requests carry one byte of JSON text (req_data_byte) or an end-of-text
// mark (req_is_end). Outside a string every byte but a double quote is
// dropped. Inside a string each request gives zero to six results on the
// rsp_ channel: decoded UTF-8 bytes (kind data), a string end, or an error
// that closes the string. rsp_last flags the final result of a request.
//
// The front end classifies one request per cycle unless the queue is full
// and queues a command; the back end expands a command into one result per
// cycle while rsp_ready is high. Throughput is one request per cycle while
// each gives at most one result; a request with more results holds the back
// end until its last one is taken, and the queue absorbs such bursts.
//
// When the receiver stalls, the current result holds and the queue fills;
// req_ready falls only when the queue is full. Reset empties the queue and
// returns the parser to idle, outside any string.
module json_string_unescape_utf8_top import jsu_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   logic    push, pop, q_empty, q_full;
   cmd_type push_cmd, head_cmd;

   jsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_is_end    (req_is_end),
      .push          (push),
      .push_cmd      (push_cmd),
      .q_full        (q_full)
   );

   jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .q_empty        (q_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule
